// File: design/dram_address_xor_bank_mapper_macros.svh
// assertion macros for the dram xor bank address mapper
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef DRAM_ADDRESS_XOR_BANK_MAPPER_MACROS_SVH
`define DRAM_ADDRESS_XOR_BANK_MAPPER_MACROS_SVH

// same-cycle implication, checks off while reset is asserted
`define DXBM_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checks off while reset is asserted
`define DXBM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/dxbm_pkg.sv
// shared types, constants and helper functions of the dram xor bank mapper
// no dependencies; imported by the mapper datapath and the top level
`default_nettype none

package dxbm_pkg;

	// address and field geometry
	localparam int ADDR_BITS  = 40;
	localparam int BANK_W     = 5;
	localparam int CNT_W      = 3;
	localparam int MAX_HASHES = 5;
	localparam int HASH_REGS  = 5;
	localparam int TZ_W       = $clog2(ADDR_BITS);
	localparam int IDX_W      = 3;
	localparam int TDATA_W    = 128;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_HASH_COUNT  = 3'd0;
	localparam logic [IDX_W-1:0] REG_BANK_HASH_0 = 3'd1;
	localparam logic [IDX_W-1:0] REG_BANK_HASH_4 = 3'd5;
	localparam logic [IDX_W-1:0] REG_ROW_MASK    = 3'd6;
	localparam logic [IDX_W-1:0] REG_COL_MASK    = 3'd7;

	// reset values
	localparam logic [CNT_W-1:0] HASH_COUNT_RESET = 3'd5;
	localparam logic [HASH_REGS-1:0][ADDR_BITS-1:0] BANK_HASH_RESET = {
		40'h00_0001_b300,
		40'h00_0012_0000,
		40'h00_0009_0000,
		40'h00_0004_8000,
		40'h00_0000_4080
	};
	localparam logic [ADDR_BITS-1:0] ROW_MASK_RESET = 40'h0f_fffc_0000;
	localparam logic [ADDR_BITS-1:0] COL_MASK_RESET = 40'h00_0000_1fff;

	// configuration seen by the datapath
	typedef struct packed {
		logic [CNT_W-1:0]                    hash_count;
		logic [HASH_REGS-1:0][ADDR_BITS-1:0] bank_hash;
		logic [ADDR_BITS-1:0]                row_field_mask;
		logic [ADDR_BITS-1:0]                column_field_mask;
	} cfg_t;

	// request fields, last field in the lowest bits
	typedef struct packed {
		logic [ADDR_BITS-1:0] column_in;
		logic [ADDR_BITS-1:0] row_in;
		logic [BANK_W-1:0]    bank_in;
		logic [ADDR_BITS-1:0] physical_address;
	} req_t;

	// result fields, last field in the lowest bits
	typedef struct packed {
		logic [ADDR_BITS-1:0] physical_out;
		logic [ADDR_BITS-1:0] column_out;
		logic [ADDR_BITS-1:0] row_out;
		logic [BANK_W-1:0]    bank_out;
	} res_t;

	localparam int REQ_W = $bits(req_t);
	localparam int RES_W = $bits(res_t);

	// trailing zero count, zero for an all-zero mask
	function automatic logic [TZ_W-1:0] trailing_zeros(input logic [ADDR_BITS-1:0] v);
		logic [TZ_W-1:0] n;
		n = '0;
		for (int i = ADDR_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = TZ_W'(i);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: design/dxbm_mapper.sv
// combinational datapath of the dram xor bank mapper: decode and compose
// depends on dxbm_pkg for the config, request and result types
`default_nettype none

module dxbm_mapper (
	input  wire logic          kind,
	input  wire dxbm_pkg::req_t req,
	input  wire dxbm_pkg::cfg_t cfg,
	output dxbm_pkg::res_t      res
);
	import dxbm_pkg::*;

	logic [CNT_W-1:0]                    n_sat;
	logic [HASH_REGS-1:0]                active;
	logic [TZ_W-1:0]                     tz_row;
	logic [TZ_W-1:0]                     tz_col;
	logic [HASH_REGS-1:0][ADDR_BITS-1:0] free_bits;
	logic [HASH_REGS-1:0][ADDR_BITS-1:0] flip;
	logic [HASH_REGS-1:0][HASH_REGS-1:0] couple;
	logic [HASH_REGS-1:0]                base_par;
	logic [HASH_REGS-1:0]                do_flip;
	logic [ADDR_BITS-1:0]                p_comp;
	logic [ADDR_BITS-1:0]                flip_all;
	logic [BANK_W-1:0]                   bank_fwd;
	logic                                acc;

	// saturated hash count and active mask lanes
	always_comb begin
		n_sat = (cfg.hash_count > CNT_W'(MAX_HASHES)) ? CNT_W'(MAX_HASHES) : cfg.hash_count;
		for (int i = 0; i < HASH_REGS; i++) begin
			active[i] = (i < int'(n_sat));
		end
	end

	assign tz_row = trailing_zeros(cfg.row_field_mask);
	assign tz_col = trailing_zeros(cfg.column_field_mask);

	// flip bit of each mask and how each flip feeds the other parities
	always_comb begin
		for (int i = 0; i < HASH_REGS; i++) begin
			free_bits[i] = cfg.bank_hash[i] & ~cfg.column_field_mask & ~cfg.row_field_mask;
			flip[i]      = free_bits[i] & (~free_bits[i] + 1'b1);
		end
		for (int i = 0; i < HASH_REGS; i++) begin
			for (int j = 0; j < HASH_REGS; j++) begin
				couple[i][j] = |(flip[j] & cfg.bank_hash[i]);
			end
		end
	end

	// forward: parity hashes for the bank
	always_comb begin
		bank_fwd = '0;
		for (int i = 0; i < BANK_W; i++) begin
			if (i < HASH_REGS) begin
				bank_fwd[i] = active[i] & (^(req.physical_address & cfg.bank_hash[i]));
			end
		end
	end

	// reverse: place row and column, then resolve the flip chain on parities
	always_comb begin
		p_comp = ((req.row_in << tz_row) | (req.column_in << tz_col));
		for (int i = 0; i < HASH_REGS; i++) begin
			base_par[i] = ^(p_comp & cfg.bank_hash[i]);
		end
		do_flip  = '0;
		flip_all = '0;
		for (int i = 0; i < HASH_REGS; i++) begin
			acc = base_par[i] ^ req.bank_in[i];
			for (int j = 0; j < i; j++) begin
				acc = acc ^ (do_flip[j] & couple[i][j]);
			end
			do_flip[i] = active[i] & acc;
			if (do_flip[i]) begin
				flip_all = flip_all ^ flip[i];
			end
		end
	end

	// result select by kind, unused fields zero
	always_comb begin
		res = '0;
		if (!kind) begin
			res.bank_out   = bank_fwd;
			res.row_out    = (req.physical_address & cfg.row_field_mask) >> tz_row;
			res.column_out = (req.physical_address & cfg.column_field_mask) >> tz_col;
		end else begin
			res.physical_out = p_comp ^ flip_all;
		end
	end

endmodule

`default_nettype wire

// File: design/dram_address_xor_bank_mapper.sv
// top level of the dram xor bank mapper: stream ports, config registers, pipeline
// depends on dxbm_pkg, dxbm_mapper and dram_address_xor_bank_mapper_macros.svh
//
// usage:
//   requests enter on the s_axis channel; s_axis_tuser is the kind
//   (0 decode a physical address into bank, row and column, 1 compose a
//   physical address from bank, row and column). results leave on m_axis,
//   one word per request, in request order.
//   configuration goes through cfg_we / cfg_index / cfg_data, one register
//   per cycle with no wait; write only while no request is in flight.
//   throughput: one word per cycle while m_axis_tready is high, set by the
//   two registers around the combinational mapper datapath (input stage
//   s1, result stage s2). an accepted word is registered in s1, passes the
//   mapper and is registered in s2, which drives m_axis.
//   stall: while m_axis_tready is low the result holds in s2 and one more
//   word can still be taken into s1; s_axis_tready then drops.
//   reset: arst_n clears the valid bits of both stages and loads the default
//   hash masks, hash count 5 and the default row and column field masks.
`default_nettype none
`include "dram_address_xor_bank_mapper_macros.svh"

module dram_address_xor_bank_mapper (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// physical_address[39:0], bank_in[44:40], row_in[84:45], column_in[124:85]
	input  wire logic [dxbm_pkg::TDATA_W-1:0]   s_axis_tdata,
	// kind[0]
	input  wire logic                           s_axis_tuser,
	// result channel
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// bank_out[4:0], row_out[44:5], column_out[84:45], physical_out[124:85]
	output logic [dxbm_pkg::TDATA_W-1:0]        m_axis_tdata,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [dxbm_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [dxbm_pkg::ADDR_BITS-1:0] cfg_data
);
	import dxbm_pkg::*;

	cfg_t  cfg_q;
	logic  v_s1;
	logic  kind_s1;
	req_t  req_s1;
	logic  v_s2;
	res_t  res_s2;
	res_t  res_comb;
	logic  adv_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hash_count        <= HASH_COUNT_RESET;
			cfg_q.bank_hash         <= BANK_HASH_RESET;
			cfg_q.row_field_mask    <= ROW_MASK_RESET;
			cfg_q.column_field_mask <= COL_MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HASH_COUNT: cfg_q.hash_count        <= cfg_data[CNT_W-1:0];
				REG_ROW_MASK:   cfg_q.row_field_mask    <= cfg_data;
				REG_COL_MASK:   cfg_q.column_field_mask <= cfg_data;
				default: begin
					if (cfg_index inside {[REG_BANK_HASH_0:REG_BANK_HASH_4]}) begin
						cfg_q.bank_hash[IDX_W'(cfg_index - REG_BANK_HASH_0)] <= cfg_data;
					end
				end
			endcase
		end
	end

	// handshake: s2 moves when empty or taken, s1 moves when empty or when s2 moves
	assign adv_s2        = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv_s2;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			req_s1  <= req_t'(s_axis_tdata[REQ_W-1:0]);
		end
	end

	// mapper datapath
	dxbm_mapper u_mapper (
		.kind (kind_s1),
		.req  (req_s1),
		.cfg  (cfg_q),
		.res  (res_comb)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_s2};

	// checks
	`DXBM_ASSERT_NEXT(a_accept_lands_s1, clk, arst_n, s_axis_tvalid && s_axis_tready, v_s1, "accepted word missing from input stage")
	`DXBM_ASSERT_NEXT(a_s1_moves_out, clk, arst_n, v_s1 && adv_s2, m_axis_tvalid, "input stage word lost on the way to the output")
	`DXBM_ASSERT_NEXT(a_fwd_no_phys, clk, arst_n, v_s1 && adv_s2 && !kind_s1, res_s2.physical_out == '0, "decode result carries a physical address")
	`DXBM_ASSERT_NEXT(a_rev_no_loc, clk, arst_n, v_s1 && adv_s2 && kind_s1, res_s2.bank_out == '0 && res_s2.row_out == '0 && res_s2.column_out == '0, "compose result carries a location")
	`DXBM_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !v_s2, s_axis_tready, "input stalled with an empty output stage")

endmodule

`default_nettype wire
